### src/irpdd_pkg.sv
// Package with shared types and constants for the IR pulse-distance decoder.
`default_nettype none

package irpdd_pkg;

	localparam int unsigned NUM_CFG_REGS = 8;
	localparam int unsigned CFG_IDX_W = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [7:0] byte_t;
	typedef byte_t cfg_array_t [NUM_CFG_REGS];

	localparam cfg_idx_t REG_LEADER_LOW  = 3'd0;
	localparam cfg_idx_t REG_LEADER_HIGH = 3'd1;
	localparam cfg_idx_t REG_ZERO_LOW    = 3'd2;
	localparam cfg_idx_t REG_ZERO_HIGH   = 3'd3;
	localparam cfg_idx_t REG_ONE_LOW     = 3'd4;
	localparam cfg_idx_t REG_ONE_HIGH    = 3'd5;
	localparam cfg_idx_t REG_REPEAT_LOW  = 3'd6;
	localparam cfg_idx_t REG_REPEAT_HIGH = 3'd7;

	localparam cfg_array_t CFG_RESET = '{
		8'h69, 8'h7F, 8'h03, 8'h0B, 8'h0C, 8'h14, 8'h54, 8'h5C
	};

	localparam logic FUNC_EDGE     = 1'b0;
	localparam logic FUNC_OVERFLOW = 1'b1;

	typedef struct packed {
		logic armed;
		logic half_timeout;
		logic timer_running;
		logic [5:0] bits_left;
		byte_t command_byte;
		byte_t check_byte;
	} dec_state_t;

endpackage

`default_nettype wire

### src/ir_pulse_distance_decoder_unit.sv
// Top level of the IR pulse-distance frame decoder with its window registers.
// An accepted word is registered in the input register and decoded from there; a command
// word is then written to the output register when the output is free.
// Throughput: one word per cycle; the input stalls only while a result waits behind a
// stalled output word.
// Reset clears the decoder state and the output valid and loads the default windows.
`default_nettype none

module ir_pulse_distance_decoder_unit #(
	parameter int unsigned FRAME_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                func,
	input  wire logic [7:0]          interval,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [7:0]               command,
	output logic                     from_repeat,
	input  wire logic                cfg_we,
	input  wire irpdd_pkg::cfg_idx_t cfg_index,
	input  wire logic [7:0]          cfg_data
);
	import irpdd_pkg::*;

	localparam logic [5:0] FRAME_LOAD = FRAME_BITS[5:0];

	byte_t cfg_q [NUM_CFG_REGS];
	dec_state_t state_q;
	dec_state_t state_d;

	logic valid_s1;
	logic func_s1;
	logic [7:0] interval_s1;

	logic out_valid_q;
	logic [7:0] command_q;
	logic from_repeat_q;

	logic res_valid;
	logic res_repeat;
	logic adv_s1;
	logic out_free;
	logic in_accept;

	logic win_leader;
	logic win_zero;
	logic win_one;
	logic win_repeat;
	logic bit_val;
	logic frame_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG_REGS; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && (!res_valid || out_free);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !adv_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1     <= func;
			interval_s1 <= interval;
		end
	end

	assign win_leader = (interval_s1 > cfg_q[REG_LEADER_LOW]) &&
		(interval_s1 < cfg_q[REG_LEADER_HIGH]);
	assign win_zero   = (interval_s1 > cfg_q[REG_ZERO_LOW]) &&
		(interval_s1 < cfg_q[REG_ZERO_HIGH]);
	assign win_one    = (interval_s1 > cfg_q[REG_ONE_LOW]) &&
		(interval_s1 < cfg_q[REG_ONE_HIGH]);
	assign win_repeat = (interval_s1 > cfg_q[REG_REPEAT_LOW]) &&
		(interval_s1 < cfg_q[REG_REPEAT_HIGH]);

	always_comb begin
		state_d    = state_q;
		frame_done = 1'b0;
		res_repeat = 1'b0;
		bit_val    = 1'b0;
		if (func_s1 == FUNC_OVERFLOW) begin
			if (state_q.timer_running) begin
				if (!state_q.half_timeout) begin
					state_d.half_timeout = 1'b1;
				end else begin
					state_d.armed         = 1'b0;
					state_d.half_timeout  = 1'b0;
					state_d.timer_running = 1'b0;
				end
			end
		end else if (!state_q.armed) begin
			state_d.armed         = 1'b1;
			state_d.timer_running = 1'b1;
		end else if (win_leader) begin
			state_d.bits_left = FRAME_LOAD;
		end else if (win_zero || win_one) begin
			bit_val = !win_zero;
			if (state_q.bits_left != 6'd0) begin
				for (int k = 0; k < 8; k++) begin
					if (state_q.bits_left == 6'(k + 1)) begin
						state_d.check_byte[k] = bit_val;
					end
					if (state_q.bits_left == 6'(k + 9)) begin
						state_d.command_byte[k] = !bit_val;
					end
				end
				state_d.bits_left = state_q.bits_left - 6'd1;
			end
		end else if (win_repeat) begin
			frame_done = 1'b1;
			res_repeat = 1'b1;
		end else if (state_q.bits_left == 6'd0) begin
			state_d.armed         = 1'b0;
			state_d.half_timeout  = 1'b0;
			state_d.timer_running = 1'b0;
			frame_done            = 1'b1;
		end
		res_valid = valid_s1 && frame_done &&
			(state_q.command_byte == state_q.check_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && res_valid) begin
			command_q     <= state_q.check_byte;
			from_repeat_q <= res_repeat;
		end
	end

	assign out_valid   = out_valid_q;
	assign command     = command_q;
	assign from_repeat = from_repeat_q;

endmodule

`default_nettype wire

### sim/ir_pulse_distance_decoder_unit_tb.sv
// Self-checking testbench for the IR pulse-distance decoder with random frames and windows.
`timescale 1ns / 1ps

module ir_pulse_distance_decoder_unit_tb;
	import irpdd_pkg::*;

	localparam int FRAME_BITS = 32;
	localparam int GAP_PCT = 6;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int WIN_LEADER = 0;
	localparam int WIN_ZERO = 1;
	localparam int WIN_ONE = 2;
	localparam int WIN_REPEAT = 3;
	localparam int NUM_DIR_ROWS = 25;

	typedef struct packed {
		byte_t cmd;
		logic  rep;
	} cmd_word_t;

	typedef struct packed {
		logic  f;
		byte_t v;
		logic  typed;
		logic  has;
		byte_t cmd;
		logic  rep;
	} dir_row_t;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	logic     func;
	logic [7:0] interval;
	logic     out_valid;
	logic     out_stall;
	logic [7:0] command;
	logic     from_repeat;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	logic [7:0] cfg_data;

	dec_state_t  dec;
	cfg_array_t  win;
	cmd_word_t   pending_cmds [$];
	cmd_word_t   head_cmd;
	int          mismatches;
	int          cycles;
	int          words_sent;
	bit          quiet;

	dir_row_t dir_rows [NUM_DIR_ROWS] = '{
		'{FUNC_OVERFLOW, 8'd0,   1'b1, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd0,   1'b1, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd255, 1'b1, 1'b1, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd255, 1'b1, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd88,  1'b1, 1'b1, 8'h00, 1'b1},
		'{FUNC_EDGE,     8'd7,   1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd15,  1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_OVERFLOW, 8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_OVERFLOW, 8'd0,   1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_OVERFLOW, 8'd170, 1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd200, 1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd110, 1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd3,   1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd11,  1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd4,   1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd19,  1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd105, 1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd126, 1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_OVERFLOW, 8'd85,  1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd88,  1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_OVERFLOW, 8'd0,   1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd0,   1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
		'{FUNC_EDGE,     8'd1,   1'b0, 1'b0, 8'h00, 1'b0}
	};

	ir_pulse_distance_decoder_unit #(
		.FRAME_BITS(FRAME_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.interval(interval),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.command(command),
		.from_repeat(from_repeat),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic in_win(input byte_t v, input int w);
		return v > win[2 * w] && v < win[2 * w + 1];
	endfunction

	function automatic void take_bit(input logic b);
		int p;
		p = dec.bits_left;
		if (p == 0) begin
			return;
		end
		if (p <= 8) begin
			dec.check_byte[p - 1] = b;
		end else if (p <= 16) begin
			dec.command_byte[p - 9] = ~b;
		end
		dec.bits_left = 6'(p - 1);
	endfunction

	function automatic logic finish_frame(input logic r, output cmd_word_t res);
		res.cmd = dec.check_byte;
		res.rep = r;
		return dec.command_byte == dec.check_byte;
	endfunction

	function automatic logic decode_word(input logic f, input byte_t v, output cmd_word_t res);
		res = '0;
		if (f == FUNC_OVERFLOW) begin
			if (dec.timer_running) begin
				if (!dec.half_timeout) begin
					dec.half_timeout = 1'b1;
				end else begin
					dec.armed = 1'b0;
					dec.half_timeout = 1'b0;
					dec.timer_running = 1'b0;
				end
			end
			return 1'b0;
		end
		if (!dec.armed) begin
			dec.armed = 1'b1;
			dec.timer_running = 1'b1;
			return 1'b0;
		end
		if (in_win(v, WIN_LEADER)) begin
			dec.bits_left = 6'(FRAME_BITS);
		end else if (in_win(v, WIN_ZERO)) begin
			take_bit(1'b0);
		end else if (in_win(v, WIN_ONE)) begin
			take_bit(1'b1);
		end else if (in_win(v, WIN_REPEAT)) begin
			return finish_frame(1'b1, res);
		end else if (dec.bits_left == 0) begin
			dec.armed = 1'b0;
			dec.timer_running = 1'b0;
			dec.half_timeout = 1'b0;
			return finish_frame(1'b0, res);
		end
		return 1'b0;
	endfunction

	function automatic byte_t pick_in(input int w);
		int lo;
		int hi;
		lo = win[2 * w];
		hi = win[2 * w + 1];
		if (hi > lo + 1) begin
			return byte_t'($urandom_range(hi - 1, lo + 1));
		end
		return byte_t'($urandom);
	endfunction

	function automatic byte_t pick_out();
		byte_t v;
		repeat (16) begin
			v = byte_t'($urandom);
			if (!in_win(v, WIN_LEADER) && !in_win(v, WIN_ZERO) && !in_win(v, WIN_ONE) &&
					!in_win(v, WIN_REPEAT)) begin
				return v;
			end
		end
		return $urandom_range(1) ? 8'd255 : 8'd0;
	endfunction

	task automatic send_row(input dir_row_t r);
		cmd_word_t res;
		logic got;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < GAP_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = r.f;
		interval = r.v;
		do @(posedge clk); while (in_stall);
		got = decode_word(r.f, r.v, res);
		if (r.typed) begin
			got = r.has;
			res.cmd = r.cmd;
			res.rep = r.rep;
		end
		if (got) begin
			pending_cmds.push_back(res);
		end
		words_sent++;
	endtask

	task automatic send_word(input logic f, input byte_t v);
		dir_row_t r;
		r = '0;
		r.f = f;
		r.v = v;
		send_row(r);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_windows(input cfg_array_t w);
		for (int i = 0; i < NUM_CFG_REGS; i++) begin
			@(negedge clk);
			cfg_we = 1'b1;
			cfg_index = cfg_idx_t'(i);
			cfg_data = w[i];
			@(posedge clk);
			win[i] = w[i];
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_traffic(input int n);
		int target;
		int kind;
		int cut;
		byte_t c;
		logic [31:0] frame;
		target = words_sent + n;
		while (words_sent < target) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				if (!dec.armed) begin
					send_word(FUNC_EDGE, byte_t'($urandom));
				end
				send_word(FUNC_EDGE, pick_in(WIN_LEADER));
				c = byte_t'($urandom);
				frame = {16'($urandom), ~c, c};
				if ($urandom_range(3) == 0) begin
					frame = frame ^ (32'd1 << $urandom_range(31));
				end
				cut = ($urandom_range(9) == 0) ? $urandom_range(31) : 0;
				for (int p = FRAME_BITS; p > cut; p--) begin
					if ($urandom_range(39) == 0) begin
						send_word(FUNC_OVERFLOW, byte_t'($urandom));
					end
					send_word(FUNC_EDGE, pick_in(frame[p - 1] ? WIN_ONE : WIN_ZERO));
				end
				send_word(FUNC_EDGE, pick_out());
				repeat ($urandom_range(2)) send_word(FUNC_EDGE, pick_in(WIN_REPEAT));
			end else if (kind < 80) begin
				repeat ($urandom_range(2, 1)) send_word(FUNC_OVERFLOW, byte_t'($urandom));
			end else if (kind < 90) begin
				send_word(FUNC_EDGE, pick_in(WIN_REPEAT));
			end else begin
				send_word(logic'($urandom_range(1)), byte_t'($urandom));
			end
		end
	endtask

	always @(negedge clk) begin
		out_stall = !quiet && $urandom_range(99) < GAP_PCT;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_cmds.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word: command %h from_repeat %b", $time,
					command, from_repeat);
			end else begin
				head_cmd = pending_cmds.pop_front();
				if (command !== head_cmd.cmd) begin
					mismatches++;
					$display("%0t: command expected %h actual %h", $time, head_cmd.cmd, command);
				end
				if (from_repeat !== head_cmd.rep) begin
					mismatches++;
					$display("%0t: from_repeat expected %b actual %b", $time, head_cmd.rep,
						from_repeat);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL ir_pulse_distance_decoder_unit");
			$finish;
		end
	end

	initial begin
		cfg_array_t plan;
		int lo;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_EDGE;
		interval = 8'd0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LEADER_LOW;
		cfg_data = 8'd0;
		mismatches = 0;
		cycles = 0;
		words_sent = 0;
		quiet = 1'b0;
		dec = '0;
		win = CFG_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NUM_DIR_ROWS; i++) begin
			send_row(dir_rows[i]);
		end
		run_traffic(700);

		drain();
		for (int w = 0; w < 4; w++) begin
			lo = $urandom_range(230);
			plan[2 * w] = byte_t'(lo);
			plan[2 * w + 1] = byte_t'(lo + $urandom_range(25, 2));
		end
		set_windows(plan);
		run_traffic(350);

		// Every window spans 1 to 254, so the leader window wins every edge inside that range.
		drain();
		quiet = 1'b1;
		set_windows('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
		run_traffic(200);
		quiet = 1'b0;

		drain();
		set_windows('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
		run_traffic(200);

		drain();
		set_windows(CFG_RESET);
		run_traffic(375);

		drain();
		if (mismatches == 0) begin
			$display("PASS ir_pulse_distance_decoder_unit");
		end else begin
			$display("FAIL ir_pulse_distance_decoder_unit");
		end
		$finish;
	end

endmodule

### files.f
src/irpdd_pkg.sv
src/ir_pulse_distance_decoder_unit.sv
sim/ir_pulse_distance_decoder_unit_tb.sv
